@@ rtl/core/rca_pkg.sv @@
package rca_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SubW  = 10;
  localparam int unsigned AddrW = 7;
  localparam int unsigned ModeW = 2;

  localparam logic [ModeW-1:0] MODE_TICK  = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ  = 2'd2;

  localparam logic [AddrW-1:0] ADDR_SUBSEC = 7'd0;
  localparam logic [AddrW-1:0] ADDR_SEC    = 7'd1;
  localparam logic [AddrW-1:0] ADDR_UPDATE = 7'd2;
  localparam logic [AddrW-1:0] ADDR_USER   = 7'd9;

  localparam logic [3:0] ALM_STATUS = 4'd0;
  localparam logic [3:0] ALM_MASK   = 4'd1;
  localparam logic [3:0] ALM_ENABLE = 4'd2;
  localparam logic [3:0] ALM_SUBSEC = 4'd3;
  localparam logic [3:0] ALM_SEC    = 4'd4;
  localparam logic [3:0] ALM_UPDATE = 4'd5;

  typedef struct packed {
    logic             vld;
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } op_t;

  typedef struct packed {
    logic             tick;
    logic [DataW-1:0] sec;
    logic [SubW-1:0]  sub;
  } live_t;

endpackage

@@ rtl/core/rca_time.sv @@
module rca_time
  import rca_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_t              op_i,
  output live_t            live_o,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] sec_q, sec_d, sh_sec_q, sh_sec_d;
  logic [SubW-1:0]  sub_q, sub_d, sh_sub_q, sh_sub_d;
  logic             set_q, set_d;

  always_comb begin
    sec_d    = sec_q;
    sub_d    = sub_q;
    sh_sec_d = sh_sec_q;
    sh_sub_d = sh_sub_q;
    set_d    = set_q;
    if (op_i.vld && op_i.mode == MODE_TICK) begin
      sub_d = sub_q + 10'd1;
      if (sub_d == '0) begin
        sec_d = sec_q + 32'd1;
      end
    end else if (op_i.vld && op_i.mode == MODE_WRITE) begin
      unique case (op_i.addr)
        ADDR_SUBSEC: sh_sub_d = op_i.data[SubW-1:0];
        ADDR_SEC:    sh_sec_d = op_i.data;
        ADDR_UPDATE: begin
          sec_d = sh_sec_q;
          sub_d = sh_sub_q;
        end
        ADDR_USER:   set_d = |op_i.data;
        default:     ;
      endcase
    end
  end

  always_comb begin
    rdata_o = '0;
    if (op_i.mode == MODE_READ) begin
      unique case (op_i.addr)
        ADDR_SUBSEC: rdata_o = {{(DataW-SubW){1'b0}}, sub_q};
        ADDR_SEC:    rdata_o = sec_q;
        ADDR_USER:   rdata_o = {{(DataW-1){1'b0}}, set_q};
        default:     rdata_o = '0;
      endcase
    end
  end

  assign live_o.tick = op_i.vld && op_i.mode == MODE_TICK;
  assign live_o.sec  = sec_d;
  assign live_o.sub  = sub_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q    <= '0;
      sub_q    <= '0;
      sh_sec_q <= '0;
      sh_sub_q <= '0;
      set_q    <= 1'b0;
    end else begin
      sec_q    <= sec_d;
      sub_q    <= sub_d;
      sh_sec_q <= sh_sec_d;
      sh_sub_q <= sh_sub_d;
      set_q    <= set_d;
    end
  end

  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_o.tick |=> sub_q == $past(sub_q) + 10'd1)
    else $error("Sub-second count did not advance on a tick.");

endmodule

@@ rtl/core/rca_alarm.sv @@
module rca_alarm
  import rca_pkg::*;
#(
  parameter int unsigned NUM_ALARMS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_t              op_i,
  input  live_t            live_i,
  output logic [DataW-1:0] rdata_o,
  output logic             irq_o
);

  logic [DataW-1:0] sh_sec_q  [NUM_ALARMS];
  logic [DataW-1:0] sh_sec_d  [NUM_ALARMS];
  logic [SubW-1:0]  sh_sub_q  [NUM_ALARMS];
  logic [SubW-1:0]  sh_sub_d  [NUM_ALARMS];
  logic [DataW-1:0] act_sec_q [NUM_ALARMS];
  logic [DataW-1:0] act_sec_d [NUM_ALARMS];
  logic [SubW-1:0]  act_sub_q [NUM_ALARMS];
  logic [SubW-1:0]  act_sub_d [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] sh_en_q, sh_en_d, act_en_q, act_en_d;
  logic [NUM_ALARMS-1:0] status_q, status_d, mask_q, mask_d;
  logic [NUM_ALARMS-1:0] slot_hit;

  always_comb begin
    for (int s = 0; s < NUM_ALARMS; s++) begin
      slot_hit[s] = ({1'b0, op_i.addr[6:4]} == 4'(s + 1));
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_ALARMS; s++) begin
      sh_sec_d[s]  = sh_sec_q[s];
      sh_sub_d[s]  = sh_sub_q[s];
      act_sec_d[s] = act_sec_q[s];
      act_sub_d[s] = act_sub_q[s];
      sh_en_d[s]   = sh_en_q[s];
      act_en_d[s]  = act_en_q[s];
      status_d[s]  = status_q[s];
      mask_d[s]    = mask_q[s];
      if (live_i.tick && act_en_q[s] && act_sec_q[s] == live_i.sec &&
          act_sub_q[s] == live_i.sub) begin
        status_d[s] = 1'b1;
      end
      if (op_i.vld && op_i.mode == MODE_WRITE && slot_hit[s]) begin
        unique case (op_i.addr[3:0])
          ALM_STATUS: if (op_i.data[0]) status_d[s] = 1'b0;
          ALM_MASK:   mask_d[s]   = op_i.data[0];
          ALM_ENABLE: sh_en_d[s]  = op_i.data[0];
          ALM_SUBSEC: sh_sub_d[s] = op_i.data[SubW-1:0];
          ALM_SEC:    sh_sec_d[s] = op_i.data;
          ALM_UPDATE: begin
            act_sec_d[s] = sh_sec_q[s];
            act_sub_d[s] = sh_sub_q[s];
            act_en_d[s]  = sh_en_q[s];
          end
          default:    ;
        endcase
      end
    end
  end

  always_comb begin
    rdata_o = '0;
    for (int s = 0; s < NUM_ALARMS; s++) begin
      if (op_i.mode == MODE_READ && slot_hit[s]) begin
        unique case (op_i.addr[3:0])
          ALM_STATUS: rdata_o = rdata_o | {{(DataW-1){1'b0}}, status_q[s]};
          ALM_MASK:   rdata_o = rdata_o | {{(DataW-1){1'b0}}, mask_q[s]};
          ALM_ENABLE: rdata_o = rdata_o | {{(DataW-1){1'b0}}, act_en_q[s]};
          ALM_SUBSEC: rdata_o = rdata_o | {{(DataW-SubW){1'b0}}, act_sub_q[s]};
          ALM_SEC:    rdata_o = rdata_o | act_sec_q[s];
          default:    ;
        endcase
      end
    end
  end

  assign irq_o = |(status_d & ~mask_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_ALARMS; s++) begin
        sh_sec_q[s]  <= '0;
        sh_sub_q[s]  <= '0;
        act_sec_q[s] <= '0;
        act_sub_q[s] <= '0;
      end
      sh_en_q  <= '0;
      act_en_q <= '0;
      status_q <= '0;
      mask_q   <= '0;
    end else begin
      for (int s = 0; s < NUM_ALARMS; s++) begin
        sh_sec_q[s]  <= sh_sec_d[s];
        sh_sub_q[s]  <= sh_sub_d[s];
        act_sec_q[s] <= act_sec_d[s];
        act_sub_q[s] <= act_sub_d[s];
      end
      sh_en_q  <= sh_en_d;
      act_en_q <= act_en_d;
      status_q <= status_d;
      mask_q   <= mask_d;
    end
  end

  a_status_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_d & ~status_q) != '0 |-> live_i.tick)
    else $error("Alarm status was set outside a tick.");

endmodule

@@ rtl/core/rtc_counter_with_alarms.sv @@
// Real-time clock with alarm compare slots.
// Requests enter on the slave stream: tuser carries the mode (tick, register
// write or register read) and tdata carries the word address and write data.
// Every request gives exactly one response on the master stream, whose tdata
// carries the read data (zero unless the request was a read) and the irq
// level as it stands after the request.
// An accepted transfer sits in the input register until the response register
// is free or being emptied; it is then processed and its response is registered.
// One request per cycle is sustained while m_axis_tready stays high; the rate is
// set by the single update pass between the input and the response register.
// Reset clears the live time, the shadow registers, all alarm slots and the valid
// flags of both pipeline registers. When the receiver stalls, the response register holds
// its transfer, one more request waits in the input register and then
// s_axis_tready drops until the response is taken.
module rtc_counter_with_alarms
  import rca_pkg::*;
#(
  parameter int unsigned NUM_ALARMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address [6:0], write_data [38:7], zero fill [39].
  input  logic [39:0] s_axis_tdata,
  // mode [1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data [31:0], irq [32], zero fill [39:33].
  output logic [39:0] m_axis_tdata
);

  logic             in_vld_q, in_vld_d;
  logic [ModeW-1:0] in_mode_q;
  logic [AddrW-1:0] in_addr_q;
  logic [DataW-1:0] in_data_q;
  logic             out_vld_q, out_vld_d;
  logic [DataW-1:0] out_rdata_q;
  logic             out_irq_q;
  logic             adv, proc, in_take;
  op_t              op;
  live_t            live;
  logic [DataW-1:0] time_rdata, alm_rdata;
  logic             irq;

  assign adv           = !out_vld_q || m_axis_tready;
  assign proc          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign op.vld  = proc;
  assign op.mode = in_mode_q;
  assign op.addr = in_addr_q;
  assign op.data = in_data_q;

  rca_time u_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .live_o  (live),
    .rdata_o (time_rdata)
  );

  rca_alarm #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_alarm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .live_i  (live),
    .rdata_o (alm_rdata),
    .irq_o   (irq)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (proc) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= s_axis_tuser;
      in_addr_q <= s_axis_tdata[AddrW-1:0];
      in_data_q <= s_axis_tdata[AddrW+DataW-1:AddrW];
    end
    if (proc) begin
      out_rdata_q <= time_rdata | alm_rdata;
      out_irq_q   <= irq;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_irq_q, out_rdata_q};

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q)
    else $error("A waiting request was dropped during a stall.");

  a_zero_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_mode_q != MODE_READ |=> out_rdata_q == '0)
    else $error("Non-read request returned nonzero read data.");

  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q)
    else $error("Processed request produced no response.");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rca_pkg::*;

  localparam int unsigned NUM_ALARMS = 4;
  localparam int unsigned RANDOM_REQS = 1550;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } req_t;

  typedef struct {
    logic [DataW-1:0] rdata;
    logic             irq;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;

  rtc_counter_with_alarms #(
    .NUM_ALARMS(NUM_ALARMS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Predicted register state of the clock.
  logic [DataW-1:0] live_sec, shadow_sec;
  logic [SubW-1:0]  live_sub, shadow_sub;
  logic             user_flag;
  logic [DataW-1:0] alm_shadow_sec [NUM_ALARMS];
  logic [SubW-1:0]  alm_shadow_sub [NUM_ALARMS];
  logic             alm_shadow_en  [NUM_ALARMS];
  logic [DataW-1:0] alm_sec        [NUM_ALARMS];
  logic [SubW-1:0]  alm_sub        [NUM_ALARMS];
  logic             alm_en         [NUM_ALARMS];
  logic             alm_status     [NUM_ALARMS];
  logic             alm_mask       [NUM_ALARMS];

  req_t  req_q[$];
  resp_t resp_q[$];
  int    total_reqs = 0;
  int    accepted_cnt = 0;
  int    sent_cnt = 0;
  int    fail_cnt = 0;
  int    tick_cnt = 0, write_cnt = 0, read_cnt = 0, other_cnt = 0;
  int    alarm_hits = 0, irq_resps = 0;

  function automatic logic [AddrW-1:0] alm_addr(int unsigned slot, logic [3:0] k);
    return AddrW'(16 + 16 * slot + k);
  endfunction

  task automatic apply_req(input req_t r, output resp_t o);
    int          off;
    int unsigned sl;
    logic [3:0]  k;
    logic        in_slot;
    off = int'(r.addr) - 16;
    sl = (off >= 0) ? (off >> 4) : 0;
    k = off[3:0];
    in_slot = (off >= 0) && (sl < NUM_ALARMS);
    o.rdata = '0;
    o.irq = 1'b0;
    case (r.mode)
      MODE_TICK: begin
        tick_cnt++;
        live_sub = live_sub + 1'b1;
        if (live_sub == '0) live_sec = live_sec + 1;
        for (int s = 0; s < NUM_ALARMS; s++) begin
          if (alm_en[s] && alm_sec[s] == live_sec && alm_sub[s] == live_sub) begin
            if (!alm_status[s]) alarm_hits++;
            alm_status[s] = 1'b1;
          end
        end
      end
      MODE_WRITE: begin
        write_cnt++;
        if (r.addr == ADDR_SUBSEC) begin
          shadow_sub = r.data[SubW-1:0];
        end else if (r.addr == ADDR_SEC) begin
          shadow_sec = r.data;
        end else if (r.addr == ADDR_UPDATE) begin
          live_sec = shadow_sec;
          live_sub = shadow_sub;
        end else if (r.addr == ADDR_USER) begin
          user_flag = (r.data != '0);
        end else if (in_slot) begin
          case (k)
            ALM_STATUS: if (r.data[0]) alm_status[sl] = 1'b0;
            ALM_MASK:   alm_mask[sl] = r.data[0];
            ALM_ENABLE: alm_shadow_en[sl] = r.data[0];
            ALM_SUBSEC: alm_shadow_sub[sl] = r.data[SubW-1:0];
            ALM_SEC:    alm_shadow_sec[sl] = r.data;
            ALM_UPDATE: begin
              alm_sec[sl] = alm_shadow_sec[sl];
              alm_sub[sl] = alm_shadow_sub[sl];
              alm_en[sl] = alm_shadow_en[sl];
            end
            default: ;
          endcase
        end
      end
      MODE_READ: begin
        read_cnt++;
        if (r.addr == ADDR_SUBSEC) begin
          o.rdata = DataW'(live_sub);
        end else if (r.addr == ADDR_SEC) begin
          o.rdata = live_sec;
        end else if (r.addr == ADDR_USER) begin
          o.rdata = DataW'(user_flag);
        end else if (in_slot) begin
          case (k)
            ALM_STATUS: o.rdata = DataW'(alm_status[sl]);
            ALM_MASK:   o.rdata = DataW'(alm_mask[sl]);
            ALM_ENABLE: o.rdata = DataW'(alm_en[sl]);
            ALM_SUBSEC: o.rdata = DataW'(alm_sub[sl]);
            ALM_SEC:    o.rdata = alm_sec[sl];
            default:    o.rdata = '0;
          endcase
        end
      end
      default: other_cnt++;
    endcase
    for (int s = 0; s < NUM_ALARMS; s++) begin
      if (alm_status[s] && !alm_mask[s]) o.irq = 1'b1;
    end
    if (o.irq) irq_resps++;
  endtask

  task automatic push_req(logic [ModeW-1:0] mode, logic [AddrW-1:0] addr,
                          logic [DataW-1:0] data);
    req_t r;
    r.mode = mode;
    r.addr = addr;
    r.data = data;
    req_q.push_back(r);
  endtask

  task automatic push_wr(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    push_req(MODE_WRITE, addr, data);
  endtask

  task automatic push_rd(logic [AddrW-1:0] addr);
    push_req(MODE_READ, addr, $urandom);
  endtask

  task automatic push_tick();
    push_req(MODE_TICK, AddrW'($urandom_range(0, 127)), $urandom);
  endtask

  task automatic push_any_rd(int unsigned slot);
    case ($urandom_range(0, 3))
      0:       push_rd(ADDR_SUBSEC);
      1:       push_rd(ADDR_SEC);
      default: push_rd(alm_addr(slot, 4'($urandom_range(0, 5))));
    endcase
  endtask

  // Sets the time, arms one slot a few ticks ahead (sometimes at a random sub-second) and ticks up to or past it.
  task automatic push_alarm_run();
    int unsigned      slot, delta, n;
    logic [DataW-1:0] sec;
    logic [SubW-1:0]  sub;
    logic [41:0]      cmp;
    slot = $urandom_range(0, NUM_ALARMS - 1);
    case ($urandom_range(0, 4))
      0:       sec = '1;
      1:       sec = '0;
      default: sec = $urandom;
    endcase
    sub = ($urandom_range(0, 2) == 0) ? SubW'($urandom_range(1018, 1023))
                                       : SubW'($urandom);
    delta = $urandom_range(1, 12);
    cmp = {sec, sub} + 42'(delta);
    if ($urandom_range(0, 7) == 0) cmp[SubW-1:0] = SubW'($urandom);
    push_wr(ADDR_SUBSEC, $urandom);
    push_wr(ADDR_SUBSEC, {22'($urandom), sub});
    push_wr(ADDR_SEC, sec);
    push_wr(ADDR_UPDATE, $urandom);
    push_wr(alm_addr(slot, ALM_SUBSEC), {22'($urandom), cmp[SubW-1:0]});
    push_wr(alm_addr(slot, ALM_SEC), cmp[41:SubW]);
    push_wr(alm_addr(slot, ALM_ENABLE),
            {31'($urandom), 1'($urandom_range(0, 5) != 0)});
    push_wr(alm_addr(slot, ALM_MASK), {31'($urandom), 1'($urandom_range(0, 3) == 0)});
    push_wr(alm_addr(slot, ALM_UPDATE), $urandom);
    n = delta + $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      push_tick();
      if ($urandom_range(0, 3) == 0) push_any_rd(slot);
    end
    push_rd(alm_addr(slot, ALM_STATUS));
    push_wr(alm_addr(slot, ALM_STATUS), {31'($urandom), 1'($urandom_range(0, 4) != 0)});
    push_rd(alm_addr(slot, ALM_STATUS));
  endtask

  initial begin
    for (int s = 0; s < NUM_ALARMS; s++) begin
      alm_shadow_sec[s] = '0;
      alm_shadow_sub[s] = '0;
      alm_shadow_en[s] = 1'b0;
      alm_sec[s] = '0;
      alm_sub[s] = '0;
      alm_en[s] = 1'b0;
      alm_status[s] = 1'b0;
      alm_mask[s] = 1'b0;
    end
    live_sec = '0;
    live_sub = '0;
    shadow_sec = '0;
    shadow_sub = '0;
    user_flag = 1'b0;

    // Reset values, wide writes, wrap of both counters and a match on the wrap.
    push_rd(ADDR_SUBSEC);
    push_rd(ADDR_SEC);
    push_rd(ADDR_USER);
    push_wr(ADDR_SUBSEC, 32'hFFFF_FFFF);
    push_wr(ADDR_SEC, 32'hFFFF_FFFF);
    push_rd(ADDR_SUBSEC);
    push_wr(ADDR_UPDATE, 32'h0);
    push_rd(ADDR_SUBSEC);
    push_wr(alm_addr(0, ALM_SUBSEC), 32'hFFFF_FC00);
    push_wr(alm_addr(0, ALM_SEC), 32'h0);
    push_wr(alm_addr(0, ALM_ENABLE), 32'hFFFF_FFFF);
    push_wr(alm_addr(0, ALM_UPDATE), 32'h0);
    push_req(MODE_TICK, 7'h7F, 32'hFFFF_FFFF);
    push_rd(ADDR_SEC);
    push_rd(alm_addr(0, ALM_STATUS));
    push_wr(alm_addr(0, ALM_MASK), 32'h1);
    push_wr(alm_addr(0, ALM_STATUS), 32'hFFFF_FFFE);
    push_wr(alm_addr(0, ALM_MASK), 32'h0);
    push_wr(alm_addr(0, ALM_STATUS), 32'h1);
    push_wr(alm_addr(0, ALM_UPDATE), 32'h0);
    push_wr(ADDR_USER, 32'h8000_0000);
    push_rd(ADDR_USER);
    push_rd(7'd3);
    push_wr(7'd15, 32'hFFFF_FFFF);
    push_rd(alm_addr(0, 4'd6));
    push_rd(7'd127);
    push_req(2'd3, 7'd1, 32'hFFFF_FFFF);

    while (req_q.size() < RANDOM_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_alarm_run();
        6, 7: begin
          for (int i = 0; i < 8; i++) begin
            push_req($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                     AddrW'($urandom_range(0, 79)), $urandom);
          end
        end
        default: begin
          for (int i = 0; i < 5; i++) begin
            push_req(ModeW'($urandom), AddrW'($urandom), $urandom);
          end
        end
      endcase
    end
    total_reqs = req_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_reqs) @(posedge clk_i);
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d transfers: %0d ticks, %0d writes, %0d reads, %0d unused-mode",
             total_reqs, tick_cnt, write_cnt, read_cnt, other_cnt);
    $display("alarm matches set %0d status bits, %0d responses had irq high",
             alarm_hits, irq_resps);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0, gap_left = 0;

  always @(negedge clk_i) begin
    req_t r;
    logic vld_n;
    logic [39:0] data_n;
    logic [1:0]  user_n;
    vld_n = 1'b0;
    data_n = s_axis_tdata;
    user_n = s_axis_tuser;
    if (rst_ni) begin
      if (s_axis_tvalid && accepted_cnt != sent_cnt) begin
        vld_n = 1'b1;
      end else begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          vld_n = 1'b1;
          data_n = {1'b0, r.data, r.addr};
          user_n = r.mode;
          burst_left--;
          sent_cnt++;
        end
      end
    end
    s_axis_tvalid <= vld_n;
    s_axis_tdata <= data_n;
    s_axis_tuser <= user_n;
  end

  always @(posedge clk_i) begin
    req_t  r;
    resp_t o;
    if (s_axis_tvalid && s_axis_tready) begin
      r.mode = s_axis_tuser;
      r.addr = s_axis_tdata[AddrW-1:0];
      r.data = s_axis_tdata[AddrW+DataW-1:AddrW];
      apply_req(r, o);
      resp_q.push_back(o);
      accepted_cnt++;
    end
  end

  // Receiver: changing stall styles, plus one long hold-off to fill the pipeline.
  int unsigned hold_left = 0, style_left = 0, stall_style = 0, pat_cnt = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && accepted_cnt >= 400) begin
        hold_done = 1'b1;
        hold_left = 120;
        rdy = 1'b0;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 2);
          style_left = $urandom_range(20, 80);
        end
        style_left--;
        pat_cnt++;
        case (stall_style)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          default: rdy = (pat_cnt % 4 != 3);
        endcase
      end
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin
    resp_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (resp_q.size() == 0) begin
        $error("response transfer with nothing expected: tdata %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_r = resp_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.rdata) begin
          $error("read_data: expected %h, actual %h", exp_r.rdata, m_axis_tdata[31:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[32] !== exp_r.irq) begin
          $error("irq: expected %b, actual %b", exp_r.irq, m_axis_tdata[32]);
          fail_cnt++;
        end
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/rca_pkg.sv
rtl/core/rca_time.sv
rtl/core/rca_alarm.sv
rtl/core/rtc_counter_with_alarms.sv
test/tb_top.sv
